// ===== src/lrc_pkg.sv =====
// Shared types and codes for the lockset race checker.
package lrc_pkg;

    typedef enum logic [1:0] {
        ST_VIRGIN     = 2'd0,
        ST_SHARED     = 2'd1,
        ST_SHARED_MOD = 2'd2,
        ST_UNTRACKED  = 2'd3
    } t_var_state;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    localparam int unsigned VAR_ID_W = 8;
    localparam int unsigned EPOCH_W  = 4;
    localparam int unsigned HELD_W   = 32;

endpackage

// ===== src/lockset_race_checker_unit.sv =====
// Lockset race checker: one read-modify-write of the entry table per active word.
// The accept edge reads the entry; the edge that fires stage 1 writes it and the result.
// One word per cycle while o_stall is low; a repeated entry is forwarded from the last write.
// Reset: synchronous, active low; clears control, then sweeps the entry table and the
// variable-seen memory one entry a cycle with o_stall held high; the table holds
// NUM_VARS*NUM_EPOCHS entries, with NUM_VARS capped at 256 ids.
module lockset_race_checker_unit
    import lrc_pkg::*;
#(
    parameter int unsigned NUM_VARS   = 256,
    parameter int unsigned NUM_EPOCHS = 16,
    parameter int unsigned NUM_LOCKS  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [VAR_ID_W-1:0] i_var_id,
    input  logic [EPOCH_W-1:0]  i_epoch,
    input  logic [HELD_W-1:0]   i_held_locks,
    input  logic                i_on_main,
    input  logic                i_threads_active,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_race_found,
    output logic [1:0]          o_var_state
);

    localparam int unsigned ID_SPAN = 1 << VAR_ID_W;
    localparam int unsigned EP_SPAN = 1 << EPOCH_W;
    localparam int unsigned VN      = (NUM_VARS < ID_SPAN) ? NUM_VARS : ID_SPAN;
    localparam int unsigned VW      = $clog2(VN);
    localparam int unsigned SEEN_N  = 1 << VW;
    localparam int unsigned EW      = (NUM_EPOCHS > 1) ? $clog2(NUM_EPOCHS) : 1;
    localparam int unsigned DEPTH   = VN * NUM_EPOCHS;
    localparam int unsigned AW      = $clog2(DEPTH);
    localparam logic [AW-1:0] NE_A   = AW'(NUM_EPOCHS);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

    typedef struct packed {
        logic                 valid;
        logic                 only_main;
        logic                 written;
        t_var_state           status;
        logic [NUM_LOCKS-1:0] locks;
    } t_entry;

    logic [VW-1:0] w_vmod [ID_SPAN];
    logic [EW-1:0] w_emod [EP_SPAN];

    for (genvar g = 0; g < ID_SPAN; g++) begin : g_vtab
        assign w_vmod[g] = VW'(g % VN);
    end
    for (genvar g = 0; g < EP_SPAN; g++) begin : g_etab
        assign w_emod[g] = EW'(g % NUM_EPOCHS);
    end

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;
    logic   r_seen_mem [SEEN_N];
    logic   r_seen_rd;

    logic                 r_clearing;
    logic [AW-1:0]        r_clr_addr;

    logic                 r_s1_valid;
    logic                 r_s1_op;
    logic [VW-1:0]        r_s1_v;
    logic [AW-1:0]        r_s1_addr;
    logic [NUM_LOCKS-1:0] r_s1_held;
    logic                 r_s1_main;
    logic                 r_s1_active;
    logic                 r_fwd_hit;
    t_entry               r_fwd_data;
    logic                 r_seen_fwd;

    logic                 r_out_valid;
    logic                 r_race;
    t_var_state           r_state;

    logic [VW-1:0]        w_v;
    logic [AW-1:0]        w_addr;
    logic [63:0]          w_held64;
    logic [NUM_LOCKS-1:0] w_held;
    logic                 w_accept;
    logic                 w_s1_fire;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    t_entry               w_wdata;
    logic                 w_seen;
    t_entry               n_entry;
    logic                 n_race;
    t_var_state           n_state;
    logic                 n_seen_set;

    assign w_v      = w_vmod[i_var_id];
    assign w_addr   = AW'(w_v) * NE_A + AW'(w_emod[i_epoch]);
    assign w_held64 = {32'b0, i_held_locks};
    assign w_held   = w_held64[NUM_LOCKS-1:0];

    assign w_s1_fire = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_clearing || (r_s1_valid && !w_s1_fire);
    assign w_accept  = i_valid && !o_stall;
    assign w_seen    = r_seen_fwd || r_seen_rd;

    always_comb begin
        t_entry               cur;
        t_entry               s;
        logic [NUM_LOCKS-1:0] lk;
        logic                 om;
        t_var_state           st;
        cur        = r_fwd_hit ? r_fwd_data : r_rd_data;
        s          = cur;
        lk         = '0;
        om         = 1'b0;
        st         = ST_VIRGIN;
        n_entry    = cur;
        n_race     = 1'b0;
        n_state    = ST_UNTRACKED;
        n_seen_set = 1'b0;
        if (r_s1_active) begin
            n_seen_set = 1'b1;
            if (!cur.valid) begin
                s.valid     = 1'b1;
                s.only_main = r_s1_main;
                s.written   = (r_s1_op == OP_WRITE);
                s.status    = ST_VIRGIN;
                s.locks     = r_s1_held;
            end
            om = s.only_main && r_s1_main;
            lk = s.locks & r_s1_held;
            st = s.status;
            if (r_s1_op == OP_READ) begin
                if (!w_seen) begin
                    n_entry = '{valid: 1'b1, only_main: r_s1_main, written: 1'b0,
                                status: ST_VIRGIN, locks: r_s1_held};
                    n_state = ST_VIRGIN;
                end else begin
                    if (st == ST_VIRGIN && !om) begin
                        st = s.written ? ST_SHARED_MOD : ST_SHARED;
                    end
                    if (st == ST_SHARED_MOD && lk == '0) begin
                        lk     = s.locks;
                        n_race = 1'b1;
                    end
                    n_entry = '{valid: 1'b1, only_main: om, written: s.written,
                                status: st, locks: lk};
                    n_state = st;
                end
            end else begin
                if (!om) begin
                    st = ST_SHARED_MOD;
                end
                if (lk == '0 && !om) begin
                    lk     = s.locks;
                    n_race = 1'b1;
                end
                n_entry = '{valid: 1'b1, only_main: om, written: 1'b1,
                            status: st, locks: lk};
                n_state = st;
            end
        end
    end

    assign w_we    = r_clearing || (w_s1_fire && r_s1_active);
    assign w_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign w_wdata = r_clearing ? '0 : n_entry;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (r_clearing) begin
            r_seen_mem[r_clr_addr[VW-1:0]] <= 1'b0;
        end else if (w_s1_fire && n_seen_set) begin
            r_seen_mem[r_s1_v] <= 1'b1;
        end
        if (w_accept) begin
            r_rd_data <= r_mem[w_addr];
            r_seen_rd <= r_seen_mem[w_v];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_A) begin
                    r_clearing <= 1'b0;
                end
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op     <= i_op;
            r_s1_v      <= w_v;
            r_s1_addr   <= w_addr;
            r_s1_held   <= w_held;
            r_s1_main   <= i_on_main;
            r_s1_active <= i_threads_active;
            r_fwd_hit   <= w_s1_fire && r_s1_active && (r_s1_addr == w_addr);
            r_fwd_data  <= n_entry;
            r_seen_fwd  <= w_s1_fire && n_seen_set && (r_s1_v == w_v);
        end
        if (w_s1_fire) begin
            r_race  <= n_race;
            r_state <= n_state;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_race_found = r_race;
    assign o_var_state  = r_state;

endmodule

// ===== src/lrc_checker.sv =====
// Port-level checks for the lockset race checker, bound to lockset_race_checker_unit.
module lrc_checker
    import lrc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_race_found,
    input logic [1:0] o_var_state
);

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_reset_sweep_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not stalled during table sweep");

    a_race_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_race_found |-> o_var_state == ST_SHARED_MOD)
        else $error("race reported on an entry that is not shared-modified");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_race_found) && $stable(o_var_state))
        else $error("stalled result word changed");

endmodule

bind lockset_race_checker_unit lrc_checker u_lrc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_race_found (o_race_found),
    .o_var_state  (o_var_state)
);

// ===== verif/tb_lockset_race_checker_unit.sv =====
// Self-checking testbench for the lockset race checker unit.
`timescale 1ns / 1ps

module tb_lockset_race_checker_unit;
    import lrc_pkg::*;

    typedef struct {
        t_op                 op;
        logic [VAR_ID_W-1:0] var_id;
        logic [EPOCH_W-1:0]  epoch;
        logic [HELD_W-1:0]   held;
        logic                on_main;
        logic                threads_active;
        logic                drain;
    } t_access;

    typedef struct {
        logic       race;
        t_var_state state;
    } t_verdict;

    typedef struct packed {
        logic              valid;
        logic              only_main;
        logic              written;
        t_var_state        status;
        logic [HELD_W-1:0] locks;
    } t_entry;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_op = 1'b0;
    logic [VAR_ID_W-1:0] i_var_id = '0;
    logic [EPOCH_W-1:0]  i_epoch = '0;
    logic [HELD_W-1:0]   i_held_locks = '0;
    logic                i_on_main = 1'b0;
    logic                i_threads_active = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_race_found;
    logic [1:0]          o_var_state;

    t_entry   entry_mem [256*16];
    logic     var_known [256];
    t_access  pending_words [$];
    t_verdict verdict_q [$];
    t_access  cur;
    int       words_in = 0;
    int       mismatches = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;
    logic     drain_next = 1'b0;

    lockset_race_checker_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_var_id         (i_var_id),
        .i_epoch          (i_epoch),
        .i_held_locks     (i_held_locks),
        .i_on_main        (i_on_main),
        .i_threads_active (i_threads_active),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_race_found     (o_race_found),
        .o_var_state      (o_var_state)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_entry blank_entry(logic main_flag, logic wr, logic [HELD_W-1:0] held);
        t_entry ent;
        ent.valid     = 1'b1;
        ent.only_main = main_flag;
        ent.written   = wr;
        ent.status    = ST_VIRGIN;
        ent.locks     = held;
        return ent;
    endfunction

    function automatic t_verdict predict_access(t_access a);
        t_verdict          r;
        t_entry            ent;
        logic [HELD_W-1:0] prior;
        int                idx;
        r.race  = 1'b0;
        r.state = ST_UNTRACKED;
        if (!a.threads_active) return r;
        idx = int'({a.var_id, a.epoch});
        ent = entry_mem[idx];
        if (a.op == OP_READ) begin
            if (!var_known[a.var_id]) begin
                var_known[a.var_id] = 1'b1;
                entry_mem[idx] = blank_entry(a.on_main, 1'b0, a.held);
                r.state = ST_VIRGIN;
                return r;
            end
            if (!ent.valid) ent = blank_entry(a.on_main, 1'b0, a.held);
            prior = ent.locks;
            ent.only_main = ent.only_main & a.on_main;
            ent.locks = ent.locks & a.held;
            if (ent.status == ST_VIRGIN && !ent.only_main)
                ent.status = ent.written ? ST_SHARED_MOD : ST_SHARED;
            if (ent.status == ST_SHARED_MOD && ent.locks == '0) begin
                ent.locks = prior;
                r.race = 1'b1;
            end
        end else begin
            var_known[a.var_id] = 1'b1;
            if (!ent.valid) ent = blank_entry(a.on_main, 1'b1, a.held);
            prior = ent.locks;
            ent.only_main = ent.only_main & a.on_main;
            ent.written = 1'b1;
            if (!ent.only_main) ent.status = ST_SHARED_MOD;
            ent.locks = ent.locks & a.held;
            if (ent.locks == '0 && !ent.only_main) begin
                ent.locks = prior;
                r.race = 1'b1;
            end
        end
        entry_mem[idx] = ent;
        r.state = ent.status;
        return r;
    endfunction

    task automatic push_access(t_op op, int v, int e, logic [HELD_W-1:0] held,
                               logic main_flag, logic active);
        t_access a;
        a.op             = op;
        a.var_id         = VAR_ID_W'(v);
        a.epoch          = EPOCH_W'(e);
        a.held           = held;
        a.on_main        = main_flag;
        a.threads_active = active;
        a.drain          = drain_next;
        drain_next       = 1'b0;
        pending_words.insert(pending_words.size(), a);
    endtask

    function automatic logic quiet_window();
        return words_in >= 700 && words_in < 1000;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                verdict_q.insert(verdict_q.size(), predict_access(cur));
                words_in++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_words.size() > 0
                        && (quiet_window() || $urandom_range(99) >= 31)
                        && !(pending_words[0].drain && verdict_q.size() > 0)) begin
                    cur = pending_words.pop_front();
                    i_valid          <= 1'b1;
                    i_op             <= cur.op;
                    i_var_id         <= cur.var_id;
                    i_epoch          <= cur.epoch;
                    i_held_locks     <= cur.held;
                    i_on_main        <= cur.on_main;
                    i_threads_active <= cur.threads_active;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected word expected none actual race=%0b state=%0d",
                             $time, o_race_found, o_var_state);
                    mismatches++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (o_race_found !== exp_v.race) begin
                        $display("%0t: race_found expected %0b actual %0b",
                                 $time, exp_v.race, o_race_found);
                        mismatches++;
                    end
                    if (o_var_state !== exp_v.state) begin
                        $display("%0t: var_state expected %0d actual %0d",
                                 $time, exp_v.state, o_var_state);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else if (!hold_done && words_in >= 400) begin
                hold_done <= 1'b1;
                hold_left <= 300;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= !quiet_window() && $urandom_range(99) < 31;
            end
        end
    end

    initial begin
        int                v;
        int                e;
        int                burst;
        logic              act;
        logic [HELD_W-1:0] guard;
        int                hot_vars [8];
        int                hot_epochs [2];

        for (int k = 0; k < 256*16; k++) entry_mem[k] = '0;
        for (int k = 0; k < 256; k++) var_known[k] = 1'b0;

        push_access(OP_READ,  5, 0, 32'h1, 1'b1, 1'b0);
        push_access(OP_READ,  5, 0, 32'h3, 1'b1, 1'b1);
        push_access(OP_READ,  5, 0, 32'h1, 1'b1, 1'b1);
        push_access(OP_READ,  5, 0, 32'h1, 1'b0, 1'b1);
        push_access(OP_WRITE, 5, 0, 32'h2, 1'b0, 1'b1);
        push_access(OP_READ,  5, 0, 32'h4, 1'b0, 1'b1);
        push_access(OP_READ,  5, 0, 32'h1, 1'b0, 1'b1);
        push_access(OP_READ,  5, 3, 32'h8, 1'b1, 1'b1);
        push_access(OP_WRITE, 5, 7, 32'h0, 1'b1, 1'b1);
        push_access(OP_WRITE, 5, 7, 32'h0, 1'b0, 1'b1);
        push_access(OP_WRITE, 255, 15, 32'hFFFF_FFFF, 1'b0, 1'b1);
        push_access(OP_READ,  255, 15, 32'h8000_0000, 1'b0, 1'b1);
        push_access(OP_READ,  255, 15, 32'h0, 1'b0, 1'b1);
        push_access(OP_READ,  0, 0, 32'h0, 1'b0, 1'b1);
        push_access(OP_READ,  0, 0, 32'h0, 1'b0, 1'b1);
        push_access(OP_WRITE, 0, 0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_access(OP_WRITE, 0, 15, 32'hFFFF_FFFF, 1'b0, 1'b0);
        push_access(OP_WRITE, 200, 9, 32'h0, 1'b1, 1'b1);
        push_access(OP_READ,  200, 9, 32'h0, 1'b1, 1'b1);
        push_access(OP_READ,  200, 9, 32'h5555_AAAA, 1'b0, 1'b1);

        for (int k = 0; k < 8; k++) hot_vars[k] = $urandom_range(255);
        for (int k = 0; k < 2; k++) hot_epochs[k] = $urandom_range(15);
        drain_next = 1'b1;
        while (pending_words.size() < 1450) begin
            if (pending_words.size() > 900 && pending_words.size() < 910) drain_next = 1'b1;
            if ($urandom_range(99) < 15) begin
                hot_vars[$urandom_range(7)]   = $urandom_range(255);
                hot_epochs[$urandom_range(1)] = $urandom_range(15);
            end
            if ($urandom_range(9) == 0) begin
                act = $urandom_range(3) != 0;
                push_access(t_op'($urandom_range(1)), $urandom_range(255),
                            $urandom_range(15), $urandom, 1'($urandom_range(1)), act);
            end else begin
                v = hot_vars[$urandom_range(7)];
                e = ($urandom_range(3) == 0) ? $urandom_range(15)
                                             : hot_epochs[$urandom_range(1)];
                guard = 32'h1 << $urandom_range(31);
                burst = $urandom_range(2, 8);
                for (int k = 0; k < burst; k++) begin
                    act = $urandom_range(19) != 0;
                    push_access(t_op'($urandom_range(1)), v, e,
                                (($urandom_range(99) < 75) ? guard : '0)
                                    | ($urandom & $urandom & $urandom),
                                $urandom_range(2) == 0, act);
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() > 0 || i_valid) @(posedge i_clk);
        while (verdict_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS lockset_race_checker_unit");
        end else begin
            $display("FAIL lockset_race_checker_unit");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL lockset_race_checker_unit");
        $finish;
    end

endmodule
